@@ rtl/cll_pkg.sv @@
// shared constants, codes and types of the circular linked list engine
package cll_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int FUNC_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [FUNC_W-1:0] FN_ADD_FRONT  = FUNC_W'(0);
   localparam logic [FUNC_W-1:0] FN_ADD_BACK   = FUNC_W'(1);
   localparam logic [FUNC_W-1:0] FN_TAKE_FRONT = FUNC_W'(2);
   localparam logic [FUNC_W-1:0] FN_TAKE_BACK  = FUNC_W'(3);
   localparam logic [FUNC_W-1:0] FN_INSERT     = FUNC_W'(4);
   localparam logic [FUNC_W-1:0] FN_REMOVE     = FUNC_W'(5);
   localparam logic [FUNC_W-1:0] FN_READ       = FUNC_W'(6);
   localparam logic [FUNC_W-1:0] FN_REVERSE    = FUNC_W'(7);
   localparam logic [FUNC_W-1:0] FN_CLEAR      = FUNC_W'(8);

   localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_RANGE = STATUS_W'(3);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_ALLOC,
      S_PLACE,
      S_WALK_RD,
      S_WALK,
      S_LINK_N,
      S_LINK_A,
      S_LINK_B,
      S_UNLINK_P,
      S_UNLINK_Q,
      S_FREE,
      S_REV_RD,
      S_REV,
      S_DONE
   } state_type;

   // write enables of the node memory, one per field
   typedef struct packed {
      logic wr_value;
      logic wr_next;
      logic wr_prev;
   } node_wen_type;

endpackage

@@ rtl/cll_node_mem.sv @@
// node memory: data words and prev/next links, one read and one write port
module cll_node_mem #(
   parameter int DEPTH      = cll_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = cll_pkg::DATA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  cll_pkg::node_wen_type      wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_WIDTH-1:0]      wr_value,
   input  logic [$clog2(DEPTH)-1:0]   wr_next,
   input  logic [$clog2(DEPTH)-1:0]   wr_prev,
   output logic [DATA_WIDTH-1:0]      rd_value,
   output logic [$clog2(DEPTH)-1:0]   rd_next,
   output logic [$clog2(DEPTH)-1:0]   rd_prev
);

   localparam int PTR_W = $clog2(DEPTH);

   // link word layout: {prev, next}
   logic [DATA_WIDTH-1:0] value_mem [DEPTH];
   logic [2*PTR_W-1:0]    link_mem  [DEPTH];

   logic [DATA_WIDTH-1:0] rd_value_ff;
   logic [2*PTR_W-1:0]    rd_link_ff;

   always_ff @(posedge clock) begin
      if (wr_en.wr_value) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (wr_en.wr_next) begin
         link_mem[wr_addr][PTR_W-1:0] <= wr_next;
      end
      if (wr_en.wr_prev) begin
         link_mem[wr_addr][2*PTR_W-1:PTR_W] <= wr_prev;
      end
   end

   always_ff @(posedge clock) begin
      rd_value_ff <= value_mem[rd_addr];
      rd_link_ff  <= link_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_link_ff[PTR_W-1:0];
   assign rd_prev  = rd_link_ff[2*PTR_W-1:PTR_W];

endmodule

@@ rtl/circular_linked_list_engine.sv @@
// circular doubly linked list engine: sequencer, list registers and result word
//
// A bounded circular doubly linked list of up to DEPTH data words. Each request word
// carries one operation (push front/back, pop front/back, insert, remove or read at a
// position, reverse, clear) and yields exactly one response word with the data word
// returned (zero when none), a status (ok, empty, full, position out of range) and the
// element count after the operation. Requests are handled one at a time: the list
// lives in a node memory with one read and one write port and a registered read, and
// every link update is a separate write. Push writes the new node and then the links
// of both neighbors, first taking a node off the free chain when one is waiting;
// insert at an inner position first walks to the node it goes before. Pop, remove and
// read walk to the node and read it; pop and remove then unlink it from both neighbors
// and put it on the free chain, unless it was the last node. The walk starts from
// whichever end is nearer, so at most (DEPTH-1)/2 links. Reverse swaps one node per
// cycle while the next node is read. A finished response waits in its own output
// register, so a new request word is taken while the previous response is still
// stalled. After reset the list is empty and the engine is ready at once: no memory
// clearing pass is needed.
module circular_linked_list_engine #(
   parameter int DEPTH      = cll_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = cll_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cll_pkg::FUNC_W-1:0]    req_func,
   input  logic [cll_pkg::VALUE_W-1:0]   req_item_value,
   input  logic [cll_pkg::POS_W-1:0]     req_position,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cll_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [cll_pkg::STATUS_W-1:0]  rsp_status,
   output logic [cll_pkg::COUNT_W-1:0]   rsp_item_count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   // common width for comparing a request position with the count
   localparam int CMP_W = (CNT_W > cll_pkg::POS_W) ? CNT_W : cll_pkg::POS_W;

   // sequencer state
   cll_pkg::state_type state_ff, state_in;

   // latched request
   logic [cll_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [DATA_WIDTH-1:0]      val_ff, val_in;
   logic [CMP_W-1:0]           pos_ff, pos_in;

   // list bookkeeping: head, tail, element count, high-water mark of nodes ever handed
   // out since the list was last empty, and the head of the chain of freed nodes
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] hwm_ff, hwm_in;
   logic [PTR_W-1:0] free_head_ff, free_head_in;

   // walk and link working registers
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic             back_ff, back_in;
   logic [PTR_W-1:0] node_ff, node_in;   // new node, or the node being unlinked
   logic [PTR_W-1:0] a_ff, a_in;         // left neighbor
   logic [PTR_W-1:0] b_ff, b_in;         // right neighbor
   logic [DATA_WIDTH-1:0]        word_ff, word_in;
   logic [cll_pkg::STATUS_W-1:0] status_ff, status_in;

   // response output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cll_pkg::VALUE_W-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic [cll_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [cll_pkg::COUNT_W-1:0]   rsp_item_count_ff, rsp_item_count_in;

   // node memory port signals
   logic [PTR_W-1:0]      rd_addr;
   cll_pkg::node_wen_type mem_wen;
   logic [PTR_W-1:0]      mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wvalue;
   logic [PTR_W-1:0]      mem_wnext;
   logic [PTR_W-1:0]      mem_wprev;
   logic [DATA_WIDTH-1:0] rd_value;
   logic [PTR_W-1:0]      rd_next;
   logic [PTR_W-1:0]      rd_prev;

   // decoded conditions
   logic             is_ins, is_del, is_rm_rd;
   logic [CMP_W-1:0] count_cmp;
   logic [CMP_W-1:0] ins_pos;
   logic             list_full, list_empty, free_avail;
   logic             ins_bad_pos, pos_bad;
   logic [CNT_W-1:0] pos_cnt, back_steps;
   logic             walk_back, at_end, rsp_free;
   logic [PTR_W-1:0] next_hop;

   cll_node_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_node_mem (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .wr_en    (mem_wen),
      .wr_addr  (mem_waddr),
      .wr_value (mem_wvalue),
      .wr_next  (mem_wnext),
      .wr_prev  (mem_wprev),
      .rd_value (rd_value),
      .rd_next  (rd_next),
      .rd_prev  (rd_prev)
   );

   // request decode and range checks
   always_comb begin
      is_ins   = (func_ff == cll_pkg::FN_ADD_FRONT) || (func_ff == cll_pkg::FN_ADD_BACK) ||
                 (func_ff == cll_pkg::FN_INSERT);
      is_del   = (func_ff == cll_pkg::FN_TAKE_FRONT) || (func_ff == cll_pkg::FN_TAKE_BACK) ||
                 (func_ff == cll_pkg::FN_REMOVE);
      is_rm_rd = (func_ff == cll_pkg::FN_REMOVE) || (func_ff == cll_pkg::FN_READ);
      count_cmp   = CMP_W'(count_ff);
      list_full   = (count_ff == CNT_W'(DEPTH));
      list_empty  = (count_ff == '0);
      // freed nodes wait on the free chain whenever more nodes were handed out than are
      // in the list
      free_avail  = (hwm_ff > count_ff);
      ins_bad_pos = (func_ff == cll_pkg::FN_INSERT) && (pos_ff > count_cmp);
      pos_bad     = (pos_ff >= count_cmp);
      // push front is insert at zero, push back is insert at the count
      if (func_ff == cll_pkg::FN_ADD_FRONT) begin
         ins_pos = '0;
      end else if (func_ff == cll_pkg::FN_ADD_BACK) begin
         ins_pos = count_cmp;
      end else begin
         ins_pos = pos_ff;
      end
      // walk from the tail when that end is nearer (only used when pos is below count)
      pos_cnt    = CNT_W'(pos_ff);
      back_steps = count_ff - CNT_W'(1) - pos_cnt;
      walk_back  = (back_steps < pos_cnt);
      at_end     = (steps_ff == '0);
      next_hop   = back_ff ? rd_prev : rd_next;
      rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cll_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = cll_pkg::S_EXEC;
            end
         end
         cll_pkg::S_EXEC: begin
            if (is_ins) begin
               if (list_full || ins_bad_pos) begin
                  state_in = cll_pkg::S_DONE;
               end else if (free_avail) begin
                  state_in = cll_pkg::S_ALLOC;
               end else begin
                  state_in = cll_pkg::S_PLACE;
               end
            end else if (is_del || (func_ff == cll_pkg::FN_READ)) begin
               if (list_empty || (is_rm_rd && pos_bad)) begin
                  state_in = cll_pkg::S_DONE;
               end else begin
                  state_in = cll_pkg::S_WALK_RD;
               end
            end else if (func_ff == cll_pkg::FN_REVERSE) begin
               state_in = list_empty ? cll_pkg::S_DONE : cll_pkg::S_REV_RD;
            end else begin
               state_in = cll_pkg::S_DONE;
            end
         end
         cll_pkg::S_ALLOC: begin
            state_in = cll_pkg::S_PLACE;
         end
         cll_pkg::S_PLACE: begin
            if (!list_empty && (pos_ff != '0) && (pos_ff != count_cmp)) begin
               state_in = cll_pkg::S_WALK_RD;
            end else begin
               state_in = cll_pkg::S_LINK_N;
            end
         end
         cll_pkg::S_WALK_RD: begin
            state_in = cll_pkg::S_WALK;
         end
         cll_pkg::S_WALK: begin
            if (at_end) begin
               if (func_ff == cll_pkg::FN_INSERT) begin
                  state_in = cll_pkg::S_LINK_N;
               end else if (func_ff == cll_pkg::FN_READ) begin
                  state_in = cll_pkg::S_DONE;
               end else if (count_ff == CNT_W'(1)) begin
                  state_in = cll_pkg::S_DONE;
               end else begin
                  state_in = cll_pkg::S_UNLINK_P;
               end
            end
         end
         cll_pkg::S_LINK_N: begin
            state_in = cll_pkg::S_LINK_A;
         end
         cll_pkg::S_LINK_A: begin
            state_in = cll_pkg::S_LINK_B;
         end
         cll_pkg::S_LINK_B: begin
            state_in = cll_pkg::S_DONE;
         end
         cll_pkg::S_UNLINK_P: begin
            state_in = cll_pkg::S_UNLINK_Q;
         end
         cll_pkg::S_UNLINK_Q: begin
            state_in = cll_pkg::S_FREE;
         end
         cll_pkg::S_FREE: begin
            state_in = cll_pkg::S_DONE;
         end
         cll_pkg::S_REV_RD: begin
            state_in = cll_pkg::S_REV;
         end
         cll_pkg::S_REV: begin
            if (at_end) begin
               state_in = cll_pkg::S_DONE;
            end
         end
         cll_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = cll_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cll_pkg::S_IDLE;
         end
      endcase
   end

   // datapath, memory accesses and handshake outputs
   always_comb begin
      func_in      = func_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      hwm_in       = hwm_ff;
      free_head_in = free_head_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      back_in      = back_ff;
      node_in      = node_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      word_in      = word_ff;
      status_in    = status_ff;

      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_item_count_in = rsp_item_count_ff;

      req_stall  = 1'b1;
      rd_addr    = cur_ff;
      mem_wen    = '0;
      mem_waddr  = node_ff;
      mem_wvalue = val_ff;
      mem_wnext  = b_ff;
      mem_wprev  = a_ff;

      case (state_ff)
         cll_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               func_in = req_func;
               val_in  = DATA_WIDTH'(req_item_value);
               pos_in  = CMP_W'(req_position);
            end
         end
         cll_pkg::S_EXEC: begin
            word_in   = '0;
            status_in = cll_pkg::ST_OK;
            // start the free chain read in case a node is taken from it
            rd_addr   = free_head_ff;
            if (is_ins) begin
               if (list_full) begin
                  status_in = cll_pkg::ST_FULL;
               end else if (ins_bad_pos) begin
                  status_in = cll_pkg::ST_RANGE;
               end else begin
                  pos_in = ins_pos;
                  if (free_avail) begin
                     node_in = free_head_ff;
                  end else begin
                     node_in = hwm_ff[PTR_W-1:0];
                     hwm_in  = hwm_ff + CNT_W'(1);
                  end
               end
            end else if (is_del || (func_ff == cll_pkg::FN_READ)) begin
               if (list_empty) begin
                  status_in = cll_pkg::ST_EMPTY;
               end else if (is_rm_rd && pos_bad) begin
                  status_in = cll_pkg::ST_RANGE;
               end else if (func_ff == cll_pkg::FN_TAKE_FRONT) begin
                  cur_in   = head_ff;
                  steps_in = '0;
                  back_in  = 1'b0;
               end else if (func_ff == cll_pkg::FN_TAKE_BACK) begin
                  cur_in   = tail_ff;
                  steps_in = '0;
                  back_in  = 1'b1;
               end else begin
                  cur_in   = walk_back ? tail_ff : head_ff;
                  steps_in = walk_back ? back_steps : pos_cnt;
                  back_in  = walk_back;
               end
            end else if (func_ff == cll_pkg::FN_REVERSE) begin
               cur_in   = head_ff;
               steps_in = count_ff - CNT_W'(1);
            end else if (func_ff == cll_pkg::FN_CLEAR) begin
               count_in = '0;
               hwm_in   = '0;
               head_in  = '0;
               tail_in  = '0;
            end
         end
         cll_pkg::S_ALLOC: begin
            // the taken node's next link points to the rest of the free chain
            free_head_in = rd_next;
         end
         cll_pkg::S_PLACE: begin
            if (list_empty) begin
               a_in = node_ff;
               b_in = node_ff;
            end else if ((pos_ff == '0) || (pos_ff == count_cmp)) begin
               a_in = tail_ff;
               b_in = head_ff;
            end else begin
               cur_in   = walk_back ? tail_ff : head_ff;
               steps_in = walk_back ? back_steps : pos_cnt;
               back_in  = walk_back;
            end
         end
         cll_pkg::S_WALK: begin
            if (at_end) begin
               if (func_ff == cll_pkg::FN_INSERT) begin
                  b_in = cur_ff;
                  a_in = rd_prev;
               end else begin
                  word_in = rd_value;
                  node_in = cur_ff;
                  a_in    = rd_prev;
                  b_in    = rd_next;
                  // last element gone: every node is free again
                  if ((func_ff != cll_pkg::FN_READ) && (count_ff == CNT_W'(1))) begin
                     count_in = '0;
                     hwm_in   = '0;
                     head_in  = '0;
                     tail_in  = '0;
                  end
               end
            end else begin
               // follow the link straight from the read data, one node per cycle
               cur_in   = next_hop;
               rd_addr  = next_hop;
               steps_in = steps_ff - CNT_W'(1);
            end
         end
         cll_pkg::S_LINK_N: begin
            mem_wen   = '{wr_value: 1'b1, wr_next: 1'b1, wr_prev: 1'b1};
            mem_waddr = node_ff;
         end
         cll_pkg::S_LINK_A: begin
            mem_wen.wr_next = 1'b1;
            mem_waddr       = a_ff;
            mem_wnext       = node_ff;
         end
         cll_pkg::S_LINK_B: begin
            mem_wen.wr_prev = 1'b1;
            mem_waddr       = b_ff;
            mem_wprev       = node_ff;
            count_in        = count_ff + CNT_W'(1);
            if (pos_ff == '0) begin
               head_in = node_ff;
            end
            if (pos_ff == count_cmp) begin
               tail_in = node_ff;
            end
         end
         cll_pkg::S_UNLINK_P: begin
            mem_wen.wr_next = 1'b1;
            mem_waddr       = a_ff;
            mem_wnext       = b_ff;
         end
         cll_pkg::S_UNLINK_Q: begin
            mem_wen.wr_prev = 1'b1;
            mem_waddr       = b_ff;
            mem_wprev       = a_ff;
         end
         cll_pkg::S_FREE: begin
            // push the removed node onto the free chain
            mem_wen.wr_next = 1'b1;
            mem_waddr       = node_ff;
            mem_wnext       = free_head_ff;
            free_head_in    = node_ff;
            count_in        = count_ff - CNT_W'(1);
            if (node_ff == head_ff) begin
               head_in = b_ff;
            end
            if (node_ff == tail_ff) begin
               tail_in = a_ff;
            end
         end
         cll_pkg::S_REV: begin
            // swap the links of this node while the next one is read
            mem_wen.wr_next = 1'b1;
            mem_wen.wr_prev = 1'b1;
            mem_waddr       = cur_ff;
            mem_wnext       = rd_prev;
            mem_wprev       = rd_next;
            rd_addr         = rd_next;
            cur_in          = rd_next;
            if (at_end) begin
               head_in = tail_ff;
               tail_in = head_ff;
            end else begin
               steps_in = steps_ff - CNT_W'(1);
            end
         end
         cll_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = cll_pkg::VALUE_W'(word_ff);
               rsp_status_in     = status_ff;
               rsp_item_count_in = cll_pkg::COUNT_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cll_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         hwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         hwm_ff       <= hwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      func_ff           <= func_in;
      val_ff            <= val_in;
      pos_ff            <= pos_in;
      free_head_ff      <= free_head_in;
      cur_ff            <= cur_in;
      steps_ff          <= steps_in;
      back_ff           <= back_in;
      node_ff           <= node_in;
      a_ff              <= a_in;
      b_ff              <= b_in;
      word_ff           <= word_in;
      status_ff         <= status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_item_count_ff <= rsp_item_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_count = rsp_item_count_ff;

   // a full status only ever comes with a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cll_pkg::ST_FULL)) |->
         (rsp_item_count == cll_pkg::COUNT_W'(DEPTH)))
      else $error("full status with a list that is not full");

   // an empty status only ever comes with an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cll_pkg::ST_EMPTY)) |-> (rsp_item_count == '0))
      else $error("empty status with a list that is not empty");

   // between requests the node bookkeeping is consistent
   a_hwm_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cll_pkg::S_IDLE) |->
         ((hwm_ff >= count_ff) && (hwm_ff <= CNT_W'(DEPTH))))
      else $error("node high-water mark out of bounds");

   // an empty list has handed out no nodes, so the free chain is empty too
   a_empty_no_nodes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == cll_pkg::S_IDLE) && (count_ff == '0)) |-> (hwm_ff == '0))
      else $error("empty list still holds allocated nodes");

endmodule
